/* sv/i2cms_pkg.sv */
`timescale 1ns / 1ps
// Package for the I2C master event sequencer: transfer types, phase codes,
// command bit constants and the sequencer state record. No dependencies.
package i2cms_pkg;

  // Width of the remaining-byte counter (8 to 32).
  localparam int COUNT_BITS = 16;

  // Request codes carried in the opcode field.
  typedef enum logic [1:0] {
    OP_START_WR = 2'd0,
    OP_START_RD = 2'd1,
    OP_EVENT    = 2'd2,
    OP_ERROR    = 2'd3
  } opcode_t;

  // Sequencer phases, one-hot.
  typedef enum logic [10:0] {
    PH_IDLE    = 11'b000_0000_0001,
    PH_SB_TX   = 11'b000_0000_0010,
    PH_ADDR_TX = 11'b000_0000_0100,
    PH_TXE     = 11'b000_0000_1000,
    PH_BTF_TX  = 11'b000_0001_0000,
    PH_SB_RX   = 11'b000_0010_0000,
    PH_ADDR_RX = 11'b000_0100_0000,
    PH_RXNE    = 11'b000_1000_0000,
    PH_L2_RX   = 11'b001_0000_0000,
    PH_L3_RX   = 11'b010_0000_0000,
    PH_ERROR   = 11'b100_0000_0000
  } phase_t;

  // Completion codes.
  localparam logic [2:0] CMP_NONE     = 3'd0;
  localparam logic [2:0] CMP_WR_DONE  = 3'd1;
  localparam logic [2:0] CMP_RD_DONE  = 3'd2;
  localparam logic [2:0] CMP_ERROR    = 3'd3;
  localparam logic [2:0] CMP_REJECTED = 3'd4;

  // Event flag bit positions.
  localparam int EV_SB   = 0;
  localparam int EV_ADDR = 1;
  localparam int EV_TXE  = 2;
  localparam int EV_BTF  = 3;
  localparam int EV_RXNE = 4;

  // Error flag bit positions.
  localparam int ER_BERR = 0;
  localparam int ER_AF   = 1;
  localparam int ER_ARLO = 2;
  localparam int ER_OVR  = 3;

  // Bus command bits.
  localparam logic [3:0] BUS_START  = 4'h1;
  localparam logic [3:0] BUS_STOP   = 4'h2;
  localparam logic [3:0] BUS_SWRST  = 4'h4;
  localparam logic [3:0] BUS_ENABLE = 4'h8;

  // ACK and POS commands.
  localparam logic [1:0] ACK_NONE = 2'd0;
  localparam logic [1:0] ACK_SET  = 2'd1;
  localparam logic [1:0] ACK_NACK = 2'd2;
  localparam logic [1:0] POS_NONE = 2'd0;
  localparam logic [1:0] POS_CLR  = 2'd1;
  localparam logic [1:0] POS_SET  = 2'd2;

  // Interrupt enable and disable bits.
  localparam logic [5:0] IRQ_EN_EVT  = 6'h01;
  localparam logic [5:0] IRQ_EN_ERR  = 6'h02;
  localparam logic [5:0] IRQ_EN_BUF  = 6'h04;
  localparam logic [5:0] IRQ_DIS_EVT = 6'h08;
  localparam logic [5:0] IRQ_DIS_ERR = 6'h10;
  localparam logic [5:0] IRQ_DIS_BUF = 6'h20;

  // Flag clear bits.
  localparam logic [4:0] CLR_ADDR = 5'h01;
  localparam logic [4:0] CLR_AF   = 5'h02;
  localparam logic [4:0] CLR_BERR = 5'h04;
  localparam logic [4:0] CLR_ARLO = 5'h08;
  localparam logic [4:0] CLR_OVR  = 5'h10;

  // Input transfer payload.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  dev_addr;
    logic [15:0] length;
    logic [7:0]  tx_byte;
    logic [4:0]  event_flags;
    logic [3:0]  error_flags;
    logic [7:0]  rx_first;
    logic [7:0]  rx_second;
  } in_t;

  // Result transfer payload.
  typedef struct packed {
    logic [2:0]  completion;
    logic [3:0]  error_report;
    logic        dr_write_valid;
    logic [7:0]  dr_write_value;
    logic        tx_taken;
    logic [3:0]  bus_cmd;
    logic [1:0]  ack_cmd;
    logic [1:0]  pos_cmd;
    logic [5:0]  irq_cmd;
    logic [4:0]  clear_cmd;
    logic [1:0]  rx_count;
    logic [15:0] rx_pair;
  } out_t;

  // Sequencer state.
  typedef struct packed {
    phase_t                  phase;
    logic [7:0]              target_address;
    logic [COUNT_BITS-1:0]   bytes_left;
  } state_t;

endpackage

/* sv/i2cms_step.sv */
`timescale 1ns / 1ps
// Next-state and command logic of the I2C master event sequencer for one item.
// Depends on i2cms_pkg.
module i2cms_step (
  input  i2cms_pkg::state_t st,
  input  i2cms_pkg::in_t    item,
  output i2cms_pkg::state_t st_nxt,
  output i2cms_pkg::out_t   res
);
  import i2cms_pkg::*;

  logic [31:0]           len_w;
  logic [COUNT_BITS-1:0] len;
  logic [COUNT_BITS-1:0] dec;
  opcode_t               op;

  // The start length is masked to the counter width.
  assign len_w = {16'h0000, item.length};
  assign len   = len_w[COUNT_BITS-1:0];
  assign dec   = st.bytes_left - COUNT_BITS'(1);
  assign op    = opcode_t'(item.opcode);

  always_comb begin
    st_nxt = st;
    res    = '0;
    unique case (op)
      // Start requests are taken only in idle with a non-zero count.
      OP_START_WR, OP_START_RD: begin
        if ((len == '0) || (st.phase != PH_IDLE)) begin
          res.completion = CMP_REJECTED;
        end else begin
          st_nxt.target_address = item.dev_addr;
          st_nxt.bytes_left     = len;
          st_nxt.phase          = (op == OP_START_WR) ? PH_SB_TX : PH_SB_RX;
          res.bus_cmd           = BUS_START | BUS_ENABLE;
          res.pos_cmd           = POS_CLR;
          res.irq_cmd           = IRQ_EN_EVT | IRQ_EN_ERR;
        end
      end
      // An error snapshot clears the reported flags and parks the block.
      OP_ERROR: begin
        res.completion   = CMP_ERROR;
        res.error_report = item.error_flags;
        if (item.error_flags[ER_BERR]) begin
          res.clear_cmd = res.clear_cmd | CLR_BERR;
          res.bus_cmd   = res.bus_cmd | BUS_SWRST;
        end
        if (item.error_flags[ER_AF]) begin
          res.clear_cmd = res.clear_cmd | CLR_AF;
          res.bus_cmd   = res.bus_cmd | BUS_STOP;
        end
        if (item.error_flags[ER_ARLO]) begin
          res.clear_cmd = res.clear_cmd | CLR_ARLO;
        end
        if (item.error_flags[ER_OVR]) begin
          res.clear_cmd = res.clear_cmd | CLR_OVR;
        end
        res.irq_cmd  = IRQ_DIS_EVT | IRQ_DIS_ERR | IRQ_DIS_BUF;
        st_nxt.phase = PH_ERROR;
      end
      // Event snapshots step the phase machine by at most one phase.
      OP_EVENT: begin
        unique case (st.phase)
          PH_SB_TX: begin
            if (item.event_flags[EV_SB]) begin
              res.dr_write_valid = 1'b1;
              res.dr_write_value = st.target_address;
              st_nxt.phase       = PH_ADDR_TX;
            end
          end
          PH_ADDR_TX: begin
            if (item.event_flags[EV_ADDR]) begin
              res.clear_cmd = CLR_ADDR;
              res.irq_cmd   = IRQ_EN_BUF;
              st_nxt.phase  = PH_TXE;
            end
          end
          PH_TXE: begin
            if (item.event_flags[EV_TXE]) begin
              if (st.bytes_left != '0) begin
                res.dr_write_valid = 1'b1;
                res.dr_write_value = item.tx_byte;
                res.tx_taken       = 1'b1;
                st_nxt.bytes_left  = dec;
              end
              if ((st.bytes_left == '0) || (dec == '0)) begin
                res.irq_cmd  = IRQ_DIS_BUF;
                st_nxt.phase = PH_BTF_TX;
              end
            end
          end
          PH_BTF_TX: begin
            if (item.event_flags[EV_BTF]) begin
              res.completion = CMP_WR_DONE;
              res.bus_cmd    = BUS_STOP;
              res.irq_cmd    = IRQ_DIS_EVT | IRQ_DIS_ERR;
              st_nxt.phase   = PH_IDLE;
            end
          end
          PH_SB_RX: begin
            if (item.event_flags[EV_SB]) begin
              res.dr_write_valid = 1'b1;
              res.dr_write_value = st.target_address | 8'h01;
              res.ack_cmd        = ACK_SET;
              st_nxt.phase       = PH_ADDR_RX;
            end
          end
          // Tail handling is chosen by the count once the address is acked.
          PH_ADDR_RX: begin
            if (item.event_flags[EV_ADDR]) begin
              res.clear_cmd = CLR_ADDR;
              if (st.bytes_left == COUNT_BITS'(1)) begin
                res.ack_cmd  = ACK_NACK;
                res.bus_cmd  = BUS_STOP;
                res.irq_cmd  = IRQ_EN_BUF;
                st_nxt.phase = PH_RXNE;
              end else if (st.bytes_left == COUNT_BITS'(2)) begin
                res.pos_cmd  = POS_SET;
                res.ack_cmd  = ACK_NACK;
                st_nxt.phase = PH_L2_RX;
              end else if (st.bytes_left == COUNT_BITS'(3)) begin
                st_nxt.phase = PH_L3_RX;
              end else begin
                res.irq_cmd  = IRQ_EN_BUF;
                st_nxt.phase = PH_RXNE;
              end
            end
          end
          PH_RXNE: begin
            if (item.event_flags[EV_RXNE]) begin
              if (st.bytes_left == COUNT_BITS'(1)) begin
                res.completion    = CMP_RD_DONE;
                res.rx_count      = 2'd1;
                res.rx_pair       = {8'h00, item.rx_first};
                res.irq_cmd       = IRQ_DIS_EVT | IRQ_DIS_ERR | IRQ_DIS_BUF;
                st_nxt.bytes_left = '0;
                st_nxt.phase      = PH_IDLE;
              end else if (st.bytes_left > COUNT_BITS'(3)) begin
                res.rx_count      = 2'd1;
                res.rx_pair       = {8'h00, item.rx_first};
                st_nxt.bytes_left = dec;
                if (dec == COUNT_BITS'(3)) begin
                  res.irq_cmd  = IRQ_DIS_BUF;
                  st_nxt.phase = PH_L3_RX;
                end
              end
            end
          end
          PH_L2_RX: begin
            if (item.event_flags[EV_BTF]) begin
              res.completion    = CMP_RD_DONE;
              res.bus_cmd       = BUS_STOP;
              res.rx_count      = 2'd2;
              res.rx_pair       = {item.rx_second, item.rx_first};
              res.irq_cmd       = IRQ_DIS_EVT | IRQ_DIS_ERR | IRQ_DIS_BUF;
              st_nxt.bytes_left = '0;
              st_nxt.phase      = PH_IDLE;
            end
          end
          PH_L3_RX: begin
            if (item.event_flags[EV_BTF]) begin
              res.ack_cmd  = ACK_NACK;
              res.rx_count = 2'd1;
              res.rx_pair  = {8'h00, item.rx_first};
              if (st.bytes_left != '0) begin
                st_nxt.bytes_left = dec;
              end
              st_nxt.phase = PH_L2_RX;
            end
          end
          // Idle, error and any stray code ignore events.
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/i2c_master_event_sequencer.sv */
`timescale 1ns / 1ps
// Top level of the I2C master event sequencer: state and result registers.
// Depends on i2cms_pkg and i2cms_step.
//
//   Channel | Ports                          | Payload
//   --------+--------------------------------+-----------------
//   input   | in_valid, in_ready, in_data    | i2cms_pkg::in_t
//   result  | out_valid, out_ready, out_data | i2cms_pkg::out_t
//
// Each accepted item gives exactly one result in the register after the
// accepting edge; one item per cycle is sustained while out_ready is high,
// set by the single state update of the phase machine.
// A synchronous active-low reset returns the block to idle, clears the
// address and count and empties the result register.
// A held result stalls input only when out_ready is low.
module i2c_master_event_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2cms_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output i2cms_pkg::out_t   out_data
);
  import i2cms_pkg::*;

  state_t state_r;
  state_t state_nxt;
  out_t   res_nxt;
  out_t   out_data_r;
  logic   out_valid_r;
  logic   in_fire;

  // Combinational step for the offered item.
  i2cms_step u_step (
    .st     (state_r),
    .item   (in_data),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // Accept whenever the result register is empty or being drained.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase          <= PH_IDLE;
      state_r.target_address <= '0;
      state_r.bytes_left     <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
